/* src/relocatable_binary_loader_defines.svh */
// Assertion macros for the relocatable binary loader.
// RBL_ASSERT is masked while rst is high; RBL_ASSERT_RST is also checked during reset.
`ifndef RELOCATABLE_BINARY_LOADER_DEFINES_SVH
`define RELOCATABLE_BINARY_LOADER_DEFINES_SVH

`ifndef SYNTHESIS
`define RBL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RBL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBL_ASSERT(label, prop, msg)
`define RBL_ASSERT_RST(label, prop, msg)
`endif

`endif

/* src/rbl_pkg.sv */
`timescale 1ns / 1ps

package rbl_pkg;

  localparam int WORD_W          = 36;
  localparam int HALF_W          = 18;
  localparam int KIND_W          = 2;
  localparam int ITEM_KIND_W     = 3;
  localparam int GROUP_WORDS_DEF = 18;

  localparam logic [HALF_W-1:0] HALF_ONES  = '1;
  localparam logic [HALF_W-1:0] RELOC_DEF  = 18'o100;

  // Item types held in item_kind
  localparam logic [ITEM_KIND_W-1:0] IT_SKIP  = 3'd0;
  localparam logic [ITEM_KIND_W-1:0] IT_CODE  = 3'd1;
  localparam logic [ITEM_KIND_W-1:0] IT_SYM   = 3'd2;
  localparam logic [ITEM_KIND_W-1:0] IT_END   = 3'd5;
  localparam logic [ITEM_KIND_W-1:0] IT_START = 3'd7;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;

  // Stream parser phase
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RELOC  = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] stream_word;
    logic              start_run;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HALF_W-1:0] address;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] symbol_name;
    logic [HALF_W-1:0] lowest_loaded;
    logic [HALF_W-1:0] highest_loaded;
    logic [HALF_W-1:0] start_address;
    logic [HALF_W-1:0] relocation;
  } out_item_t;

endpackage

/* src/rbl_step.sv */
`timescale 1ns / 1ps

// Loader state and the per-word update. The state advances on every word
// moved from the input register to the result register.
module rbl_step import rbl_pkg::*; #(
  parameter int GROUP_WORDS = GROUP_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  in_item_t          item,
  input  logic [HALF_W-1:0] relocation_base,
  output out_item_t         result
);

  localparam int GL_W = $clog2(GROUP_WORDS + 1);
  localparam logic [GL_W-1:0] GROUP_LOAD = GL_W'(GROUP_WORDS);

  // State
  phase_t                 phase;
  logic [ITEM_KIND_W-1:0] item_kind;
  logic [HALF_W-1:0]      words_left;
  logic [GL_W-1:0]        group_left;
  logic [WORD_W-1:0]      reloc_bits;
  logic [HALF_W-1:0]      reloc_now;
  logic [HALF_W-1:0]      load_pointer;
  logic                   first_of_item;
  logic [WORD_W-1:0]      held_name;
  logic                   pair_half;
  logic [HALF_W-1:0]      low_bound;
  logic [HALF_W-1:0]      high_bound;
  logic [HALF_W-1:0]      start_reg;

  phase_t                 phase_next;
  logic [ITEM_KIND_W-1:0] item_kind_next;
  logic [HALF_W-1:0]      words_left_next;
  logic [GL_W-1:0]        group_left_next;
  logic [WORD_W-1:0]      reloc_bits_next;
  logic [HALF_W-1:0]      reloc_now_next;
  logic [HALF_W-1:0]      load_pointer_next;
  logic                   first_of_item_next;
  logic [WORD_W-1:0]      held_name_next;
  logic                   pair_half_next;
  logic [HALF_W-1:0]      low_bound_next;
  logic [HALF_W-1:0]      high_bound_next;
  logic [HALF_W-1:0]      start_reg_next;

  // Values after a run restart, if any
  phase_t            phase_eff;
  logic [HALF_W-1:0] reloc_eff;
  logic [HALF_W-1:0] low_eff;
  logic [HALF_W-1:0] high_eff;

  logic [HALF_W-1:0] hdr_type;
  logic [1:0]        rbits;
  logic [HALF_W-1:0] rel_lh;
  logic [HALF_W-1:0] rel_rh;
  logic [WORD_W-1:0] rel_word;
  logic [HALF_W-1:0] words_dec;
  logic [GL_W-1:0]   group_dec;

  assign phase_eff = item.start_run ? PH_HEADER : phase;
  assign reloc_eff = item.start_run ? relocation_base : reloc_now;
  assign low_eff   = item.start_run ? HALF_ONES : low_bound;
  assign high_eff  = item.start_run ? '0 : high_bound;

  // Relocation of the halves selected by the top two bits
  assign hdr_type  = item.stream_word[WORD_W-1:HALF_W];
  assign rbits     = reloc_bits[WORD_W-1:WORD_W-2];
  assign rel_lh    = rbits[1] ? hdr_type + reloc_eff : hdr_type;
  assign rel_rh    = rbits[0] ? item.stream_word[HALF_W-1:0] + reloc_eff
                              : item.stream_word[HALF_W-1:0];
  assign rel_word  = {rel_lh, rel_rh};
  assign words_dec = words_left - 18'd1;
  assign group_dec = group_left - GL_W'(1);

  always_comb begin
    phase_next         = phase_eff;
    item_kind_next     = item_kind;
    words_left_next    = words_left;
    group_left_next    = group_left;
    reloc_bits_next    = reloc_bits;
    reloc_now_next     = reloc_eff;
    load_pointer_next  = load_pointer;
    first_of_item_next = first_of_item;
    held_name_next     = held_name;
    pair_half_next     = pair_half;
    low_bound_next     = low_eff;
    high_bound_next    = high_eff;
    start_reg_next     = start_reg;

    result             = '0;

    case (phase_eff)
      PH_RELOC: begin
        reloc_bits_next = item.stream_word;
        group_left_next = GROUP_LOAD;
        pair_half_next  = 1'b0;
        phase_next      = PH_DATA;
      end
      PH_DATA: begin
        reloc_bits_next = {reloc_bits[WORD_W-3:0], 2'b00};
        case (item_kind)
          IT_CODE: begin
            if (first_of_item) begin
              load_pointer_next = rel_rh;
            end else begin
              result.kind       = KIND_WRITE;
              result.address    = load_pointer;
              result.data       = rel_word;
              if (load_pointer < low_eff) low_bound_next = load_pointer;
              if (load_pointer > high_eff) high_bound_next = load_pointer;
              load_pointer_next = load_pointer + 18'd1;
            end
          end
          IT_SYM: begin
            if (!pair_half) begin
              held_name_next = rel_word;
              pair_half_next = 1'b1;
            end else begin
              result.kind        = KIND_SYMBOL;
              result.symbol_name = held_name;
              result.data        = rel_word;
              pair_half_next     = 1'b0;
            end
          end
          IT_END: begin
            if (first_of_item) reloc_now_next = rel_rh;
          end
          IT_START: begin
            if (first_of_item) start_reg_next = rel_rh;
          end
          default: begin
          end
        endcase
        first_of_item_next = 1'b0;
        words_left_next    = words_dec;
        group_left_next    = group_dec;
        if (words_dec == '0) begin
          phase_next = PH_HEADER;
        end else if (group_dec == '0) begin
          phase_next = PH_RELOC;
        end
      end
      default: begin
        // header word: type in left half, count in right half
        if (hdr_type == {15'd0, IT_CODE} || hdr_type == {15'd0, IT_SYM} ||
            hdr_type == {15'd0, IT_END} || hdr_type == {15'd0, IT_START}) begin
          item_kind_next = hdr_type[ITEM_KIND_W-1:0];
        end else begin
          item_kind_next = IT_SKIP;
        end
        words_left_next    = item.stream_word[HALF_W-1:0];
        first_of_item_next = 1'b1;
        pair_half_next     = 1'b0;
        group_left_next    = '0;
        phase_next = (item.stream_word[HALF_W-1:0] != '0) ? PH_RELOC : PH_HEADER;
      end
    endcase

    result.lowest_loaded  = low_bound_next;
    result.highest_loaded = high_bound_next;
    result.start_address  = start_reg_next;
    result.relocation     = reloc_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      item_kind     <= IT_SKIP;
      words_left    <= '0;
      group_left    <= '0;
      reloc_now     <= RELOC_DEF;
      load_pointer  <= '0;
      first_of_item <= 1'b1;
      pair_half     <= 1'b0;
      low_bound     <= HALF_ONES;
      high_bound    <= '0;
      start_reg     <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      item_kind     <= item_kind_next;
      words_left    <= words_left_next;
      group_left    <= group_left_next;
      reloc_now     <= reloc_now_next;
      load_pointer  <= load_pointer_next;
      first_of_item <= first_of_item_next;
      pair_half     <= pair_half_next;
      low_bound     <= low_bound_next;
      high_bound    <= high_bound_next;
      start_reg     <= start_reg_next;
    end
  end

  // Payload state, always written before it is read
  always_ff @(posedge clk) begin
    if (advance) begin
      reloc_bits <= reloc_bits_next;
      held_name  <= held_name_next;
    end
  end

endmodule

/* src/relocatable_binary_loader.sv */
`timescale 1ns / 1ps

// Relocatable binary loader: one 36-bit stream word in, one result out.
// Input channel (in_valid, in_stall, in_data): a word and a start_run flag;
// start_run restarts the run before the word, which is then read as a header.
// Output channel (out_valid, out_stall, out_data): one result per word, with
// kind none, memory write or symbol pair, plus the load bounds, start address
// and relocation base after that word.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): the relocation base
// loaded at each run restart; cfg_ready is always high. Write only when idle.
// Results are registered: an input register, then the combinational word
// update into the result register. One word is taken every cycle while
// out_stall is low; the rate is set by the loader state update, one word per
// pass. While out_stall holds, the result stays put, one further word waits
// in the input register, then in_stall is raised.
// Synchronous reset empties both registers and returns the loader to
// expecting a header with relocation base 64 and empty load bounds.
module relocatable_binary_loader import rbl_pkg::*; #(
  parameter int GROUP_WORDS = GROUP_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_data
);

`include "relocatable_binary_loader_defines.svh"

  logic              s1_valid;
  in_item_t          s1_item;
  logic              advance;
  logic [HALF_W-1:0] relocation_base;
  out_item_t         step_result;

  // Register write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      relocation_base <= RELOC_DEF;
    end else if (cfg_valid && cfg_ready) begin
      relocation_base <= cfg_data;
    end
  end

  // Handshake: word moves on when the result register is free or being taken
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  rbl_step #(
    .GROUP_WORDS (GROUP_WORDS)
  ) u_step (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .item            (s1_item),
    .relocation_base (relocation_base),
    .result          (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

  // Checks
  `RBL_ASSERT_RST(a_reset_empties, rst |=> !out_valid && !s1_valid, "registers not empty after reset")
  `RBL_ASSERT(a_stall_only_full, !s1_valid |-> !in_stall, "input stalled with empty input register")
  `RBL_ASSERT(a_write_in_bounds, out_valid && out_data.kind == KIND_WRITE |-> out_data.lowest_loaded <= out_data.address && out_data.highest_loaded >= out_data.address, "write address outside load bounds")
  `RBL_ASSERT(a_addr_only_write, out_valid && out_data.kind != KIND_WRITE |-> out_data.address == '0, "address set on a non-write result")

endmodule

/* tb/loader_scoreboard_pkg.sv */
`timescale 1ns / 1ps

package loader_scoreboard_pkg;
  import rbl_pkg::*;

  class loader_scoreboard;
    // Relocation base register as last written
    logic [HALF_W-1:0]      base_reg;

    // Loader state
    phase_t                 phase;
    logic [ITEM_KIND_W-1:0] item_kind;
    logic [HALF_W-1:0]      words_left;
    logic [4:0]             group_left;
    logic [WORD_W-1:0]      reloc_bits;
    logic [HALF_W-1:0]      reloc_now;
    logic [HALF_W-1:0]      load_ptr;
    logic                   first_word;
    logic [WORD_W-1:0]      held_name;
    logic                   pair_half;
    logic [HALF_W-1:0]      low_bound;
    logic [HALF_W-1:0]      high_bound;
    logic [HALF_W-1:0]      start_reg;

    // Outcomes of accepted words, oldest first
    out_item_t              word_outcomes[$];
    int                     errors;

    function new();
      base_reg   = RELOC_DEF;
      phase      = PH_HEADER;
      item_kind  = IT_SKIP;
      words_left = '0;
      group_left = '0;
      reloc_bits = '0;
      reloc_now  = RELOC_DEF;
      load_ptr   = '0;
      first_word = 1'b1;
      held_name  = '0;
      pair_half  = 1'b0;
      low_bound  = HALF_ONES;
      high_bound = '0;
      start_reg  = '0;
      errors     = 0;
    endfunction

    // Add the current base to the marked halves, each wrapping at 18 bits
    function logic [WORD_W-1:0] apply_reloc(logic [WORD_W-1:0] w, logic [1:0] marks);
      logic [HALF_W-1:0] lh;
      logic [HALF_W-1:0] rh;
      lh = w[WORD_W-1:HALF_W];
      rh = w[HALF_W-1:0];
      if (marks[0]) rh = rh + reloc_now;
      if (marks[1]) lh = lh + reloc_now;
      return {lh, rh};
    endfunction

    // Advance the loader by one accepted word and queue its outcome
    function void note_word(in_item_t it);
      out_item_t         res;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] rw;
      logic [HALF_W-1:0] t;
      res = '0;
      w   = it.stream_word;

      if (it.start_run) begin
        phase      = PH_HEADER;
        reloc_now  = base_reg;
        low_bound  = HALF_ONES;
        high_bound = '0;
      end

      case (phase)
        PH_RELOC: begin
          reloc_bits = w;
          group_left = 5'(GROUP_WORDS_DEF);
          pair_half  = 1'b0;
          phase      = PH_DATA;
        end
        PH_DATA: begin
          rw         = apply_reloc(w, reloc_bits[WORD_W-1:WORD_W-2]);
          reloc_bits = reloc_bits << 2;
          case (item_kind)
            IT_CODE: begin
              if (first_word) begin
                load_ptr = rw[HALF_W-1:0];
              end else begin
                res.kind    = KIND_WRITE;
                res.address = load_ptr;
                res.data    = rw;
                if (load_ptr < low_bound) low_bound = load_ptr;
                if (load_ptr > high_bound) high_bound = load_ptr;
                load_ptr = load_ptr + 1'b1;
              end
            end
            IT_SYM: begin
              if (!pair_half) begin
                held_name = rw;
                pair_half = 1'b1;
              end else begin
                res.kind        = KIND_SYMBOL;
                res.symbol_name = held_name;
                res.data        = rw;
                pair_half       = 1'b0;
              end
            end
            IT_END: begin
              if (first_word) reloc_now = rw[HALF_W-1:0];
            end
            IT_START: begin
              if (first_word) start_reg = rw[HALF_W-1:0];
            end
            default: ;
          endcase
          first_word = 1'b0;
          words_left = words_left - 1'b1;
          group_left = group_left - 1'b1;
          if (words_left == '0) phase = PH_HEADER;
          else if (group_left == '0) phase = PH_RELOC;
        end
        default: begin
          // Header word: type in the left half, word count in the right
          t = w[WORD_W-1:HALF_W];
          if (t == IT_CODE || t == IT_SYM || t == IT_END || t == IT_START)
            item_kind = t[ITEM_KIND_W-1:0];
          else
            item_kind = IT_SKIP;
          words_left = w[HALF_W-1:0];
          first_word = 1'b1;
          pair_half  = 1'b0;
          group_left = '0;
          phase      = (words_left != '0) ? PH_RELOC : PH_HEADER;
        end
      endcase

      res.lowest_loaded  = low_bound;
      res.highest_loaded = high_bound;
      res.start_address  = start_reg;
      res.relocation     = reloc_now;
      word_outcomes.push_back(res);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transaction with the oldest queued outcome
    function void check_outcome(out_item_t got);
      out_item_t want;
      if (word_outcomes.size() == 0) begin
        $error("result with no outcome pending: kind %0h address %0h", got.kind,
               got.address);
        errors++;
        return;
      end
      want = word_outcomes.pop_front();
      compare_field("kind", WORD_W'(want.kind), WORD_W'(got.kind));
      compare_field("address", WORD_W'(want.address), WORD_W'(got.address));
      compare_field("data", want.data, got.data);
      compare_field("symbol_name", want.symbol_name, got.symbol_name);
      compare_field("lowest_loaded", WORD_W'(want.lowest_loaded),
                    WORD_W'(got.lowest_loaded));
      compare_field("highest_loaded", WORD_W'(want.highest_loaded),
                    WORD_W'(got.highest_loaded));
      compare_field("start_address", WORD_W'(want.start_address),
                    WORD_W'(got.start_address));
      compare_field("relocation", WORD_W'(want.relocation),
                    WORD_W'(got.relocation));
    endfunction

    function int pending();
      return word_outcomes.size();
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rbl_pkg::*;
  import loader_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [HALF_W-1:0] cfg_data  = '0;

  loader_scoreboard sb = new();
  int               words_sent  = 0;
  int               in_quiet    = 0;
  int               out_quiet   = 0;
  int               cycle_count = 0;
  bit               restart_next = 1'b0;

  relocatable_binary_loader dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {4'($urandom()), 32'($urandom())};
  endfunction

  // Draw an idle count, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) quiet = $urandom_range(20, 60);
    return $urandom_range(0, 4);
  endfunction

  // Present one stream word and hold it until the transaction completes
  task automatic send_word(logic [WORD_W-1:0] w, logic start);
    int gap;
    gap = draw_gap(in_quiet);
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{stream_word: w, start_run: start};
    do @(posedge clk); while (in_stall);
    sb.note_word(in_data);
    words_sent++;
  endtask

  // Hold the input back until every queued outcome has been seen
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_base(logic [HALF_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.base_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One stream item: header, then data words with a relocation word per group
  task automatic send_random_item();
    int                pick;
    int                count;
    logic [HALF_W-1:0] type_field;
    logic              start;
    logic              mid;
    pick  = $urandom_range(0, 99);
    start = restart_next || ($urandom_range(0, 29) == 0);
    restart_next = 1'b0;

    if (pick >= 90) begin
      // Broken item: arbitrary header, one to 30 words, then a restart
      send_word(rand_word(), start);
      repeat ($urandom_range(1, 30)) send_word(rand_word(), 1'b0);
      restart_next = 1'b1;
      return;
    end

    if (pick < 30) type_field = HALF_W'(IT_CODE);
    else if (pick < 55) type_field = HALF_W'(IT_SYM);
    else if (pick < 63) type_field = HALF_W'(IT_END);
    else if (pick < 71) type_field = HALF_W'(IT_START);
    else if (pick < 83) begin
      case ($urandom_range(0, 3))
        0: type_field = HALF_W'(IT_SKIP);
        1: type_field = 18'd3;
        2: type_field = 18'd4;
        default: type_field = 18'd6;
      endcase
    end else type_field = HALF_W'($urandom_range(8, 18'h3ffff));

    case ($urandom_range(0, 9))
      0: count = 0;
      1, 2, 3, 4, 5: count = $urandom_range(1, 8);
      default: count = $urandom_range(9, 45);
    endcase

    send_word({type_field, HALF_W'(count)}, start);
    for (int i = 0; i < count; i++) begin
      if (i % GROUP_WORDS_DEF == 0) send_word(rand_word(), 1'b0);
      mid = ($urandom_range(0, 299) == 0);
      send_word(rand_word(), mid);
      if (mid) restart_next = 1'b1;
    end
  endtask

  // Short directed stream under the reset relocation base
  task automatic run_directed();
    // Code item: load address near the top so the load pointer wraps
    send_word({HALF_W'(IT_CODE), 18'd4}, 1'b0);
    send_word(36'hd_8000_0000, 1'b0);
    send_word({18'd0, 18'h3fffe - 18'd64}, 1'b0);
    send_word(36'hf_ffff_ffff, 1'b0);
    send_word(36'h0_0000_0000, 1'b0);
    send_word(rand_word(), 1'b0);
    // Symbol item with an odd word left over at the end of the item
    send_word({HALF_W'(IT_SYM), 18'd5}, 1'b0);
    send_word(36'hf_ffff_ffff, 1'b0);
    repeat (5) send_word(rand_word(), 1'b0);
    // End item: first word sets a new base, the extra word is ignored
    send_word({HALF_W'(IT_END), 18'd2}, 1'b0);
    send_word(36'hc_0000_0000, 1'b0);
    send_word({18'd0, 18'h01000}, 1'b0);
    send_word(rand_word(), 1'b0);
    // Start item with an extra word
    send_word({HALF_W'(IT_START), 18'd2}, 1'b0);
    send_word(rand_word(), 1'b0);
    send_word(rand_word(), 1'b0);
    send_word(rand_word(), 1'b0);
    // Empty item with a run restart
    send_word({HALF_W'(IT_SYM), 18'd0}, 1'b1);
    // Unknown type above seven
    send_word({18'h3ffff, 18'd1}, 1'b0);
    send_word(rand_word(), 1'b0);
    send_word(rand_word(), 1'b0);
  endtask

  // Result side: random stall before each transaction, then check it
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = draw_gap(out_quiet);
      @(negedge clk);
      repeat (gap) begin
        out_stall = 1'b1;
        @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_outcome(out_data);
    end
  end

  // Stimulus
  initial begin
    logic [HALF_W-1:0] next_base;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Phases under different relocation bases, extremes first
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: next_base = '0;
        1: next_base = HALF_ONES;
        2: next_base = HALF_W'($urandom_range(0, 18'h3ffff));
        default: next_base = RELOC_DEF;
      endcase
      write_base(next_base);
      restart_next = 1'b1;
      while (words_sent < 25 + (p + 1) * 270) send_random_item();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/rbl_pkg.sv
src/rbl_step.sv
src/relocatable_binary_loader.sv
tb/loader_scoreboard_pkg.sv
tb/testbench.sv
